// ===== src/bgl_pkg.sv =====
// ----------------------------------------------------------------------------
// bgl_pkg
// Shared types and constants of the battery level gauge.
// ----------------------------------------------------------------------------
package bgl_pkg;

    localparam int SAMPLES_DEF = 16;
    localparam int TRIM_DEF    = 2;

    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 16;
    localparam int PCT_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_W    = 24;

    localparam logic [LEVEL_W-1:0] EMPTY_RST  = 16'd28789;
    localparam logic [LEVEL_W-1:0] FULL_RST   = 16'd36731;
    localparam logic [LEVEL_W-1:0] FLOOR_RST  = 16'd9927;
    localparam logic [LEVEL_W-1:0] ENTER_RST  = 16'd37227;
    localparam logic [LEVEL_W-1:0] LEAVE_RST  = 16'd36235;
    localparam logic [PCT_W-1:0]   HYST_RST   = 7'd2;
    localparam logic [PCT_W-1:0]   PCT_FULL   = 7'd100;
    localparam logic [7:0]         PCT_SCALE2 = 8'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EMPTY  = 3'd0,
        REG_FULL   = 3'd1,
        REG_FLOOR  = 3'd2,
        REG_ENTER  = 3'd3,
        REG_LEAVE  = 3'd4,
        REG_HYST   = 3'd5
    } bgl_reg_idx_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_SUM,
        ST_MEAN,
        ST_CHECK,
        ST_PCT,
        ST_DIV_PCT,
        ST_UPD
    } bgl_state_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } bgl_cell_ctrl_t;

endpackage

// ===== src/bgl_cell.sv =====
// ----------------------------------------------------------------------------
// bgl_cell
// One slot of the sorting chain: inserts in order, shifts toward slot 0.
// ----------------------------------------------------------------------------
module bgl_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bgl_pkg::bgl_cell_ctrl_t       ctrl,
    input  logic [bgl_pkg::SAMPLE_W-1:0]  x,
    input  logic [bgl_pkg::SAMPLE_W-1:0]  prev_val,
    input  logic                          prev_valid,
    input  logic                          prev_lt,
    input  logic [bgl_pkg::SAMPLE_W-1:0]  next_val,
    output logic [bgl_pkg::SAMPLE_W-1:0]  val,
    output logic                          valid,
    output logic                          lt
);

    logic [bgl_pkg::SAMPLE_W-1:0] val_reg;
    logic [bgl_pkg::SAMPLE_W-1:0] val_next;
    logic                         valid_reg;
    logic                         valid_next;

    // An empty slot counts as larger than any sample
    assign lt = !valid_reg || (x < val_reg);

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            val_next = next_val;
        end
        else if (ctrl.insert && lt)
        begin
            val_next   = prev_lt ? prev_val : x;
            valid_next = valid_reg | prev_valid;
        end
    end

    // Hold payload, reset occupancy
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

// ===== src/bgl_div.sv =====
// ----------------------------------------------------------------------------
// bgl_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgl_div #(
    parameter int W = bgl_pkg::DIV_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W-1:0] quo,
    output logic         done
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    // Datapath: load operands, then one trial subtract per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    // Control: count steps and flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ===== src/battery_level_gauge_top.sv =====
// ----------------------------------------------------------------------------
// battery_level_gauge_top
// Trimmed-mean battery gauge with smoothing, percent and charge detection.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the in channel (in_valid/in_ready, sample), at most one
//   transfer per cycle; each is inserted in sorted order into a chain of
//   SAMPLES cells. The transfer of the last sample of a burst starts the
//   evaluation and in_ready stays low until the result is loaded.
//   Evaluation: the sorted chain is shifted out through the trimmed sum,
//   then the mean is formed (reciprocal multiply), the level is checked
//   against the floor, the percent is set up, the restoring divider runs
//   and the output register is loaded. A rejected burst skips the percent
//   and the divider, and a level that sits on a rail skips the divider.
//   One result per burst goes out on the out channel (out_valid/out_ready)
//   from an output register. A stalled receiver holds the result; the next
//   burst is collected meanwhile and only its finished result waits, with
//   in_ready low, until the register frees.
//   Registers are written on the cfg channel (cfg_valid/cfg_ready, always
//   ready); the user must write them only while the block is idle, and the
//   block does not enforce it. Reset clears the smoothed state, the sample
//   count and all registers to their defaults.
// ----------------------------------------------------------------------------
module battery_level_gauge_top #(
    parameter int SAMPLES = bgl_pkg::SAMPLES_DEF,
    parameter int TRIM    = bgl_pkg::TRIM_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bgl_pkg::SAMPLE_W-1:0]    sample,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bgl_pkg::PCT_W-1:0]       percent,
    output logic                            charging,
    output logic [bgl_pkg::LEVEL_W-1:0]     level,
    output logic                            rejected,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bgl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bgl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int EFF_TRIM = (TRIM <= (SAMPLES - 1) / 2) ? TRIM : (SAMPLES - 1) / 2;
    localparam int KEPT     = SAMPLES - 2 * EFF_TRIM;
    localparam int CNT_W    = $clog2(SAMPLES + 1);
    localparam int SUM_W    = bgl_pkg::SAMPLE_W + $clog2(SAMPLES + 1);
    localparam int SW       = bgl_pkg::SAMPLE_W;
    localparam int LW       = bgl_pkg::LEVEL_W;
    localparam int PW       = bgl_pkg::PCT_W;
    localparam int DW       = bgl_pkg::DIV_W;

    // Mean by reciprocal multiply: floor(x / KEPT) is exact for x below 2^MEAN_N
    localparam int     MEAN_N     = SUM_W + 4;
    localparam int     MEAN_L     = $clog2(KEPT);
    localparam int     MEAN_SH    = MEAN_N + MEAN_L;
    localparam int     MEAN_MW    = MEAN_N + 1;
    localparam int     MEAN_PW    = 2 * MEAN_N + 1;
    localparam longint MEAN_RECIP = ((longint'(1) << MEAN_SH) + longint'(KEPT) - 1)
                                    / longint'(KEPT);
    localparam logic [MEAN_MW-1:0] MEAN_M = MEAN_MW'(MEAN_RECIP);

    // Configuration registers
    logic [LW-1:0] empty_reg, full_reg, floor_reg, enter_reg, leave_reg;
    logic [PW-1:0] hyst_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= bgl_pkg::EMPTY_RST;
            full_reg  <= bgl_pkg::FULL_RST;
            floor_reg <= bgl_pkg::FLOOR_RST;
            enter_reg <= bgl_pkg::ENTER_RST;
            leave_reg <= bgl_pkg::LEAVE_RST;
            hyst_reg  <= bgl_pkg::HYST_RST;
        end
        else if (cfg_valid)
        begin
            unique case (bgl_pkg::bgl_reg_idx_t'(cfg_index))
                bgl_pkg::REG_EMPTY: empty_reg <= cfg_data;
                bgl_pkg::REG_FULL:  full_reg  <= cfg_data;
                bgl_pkg::REG_FLOOR: floor_reg <= cfg_data;
                bgl_pkg::REG_ENTER: enter_reg <= cfg_data;
                bgl_pkg::REG_LEAVE: leave_reg <= cfg_data;
                bgl_pkg::REG_HYST:  hyst_reg  <= cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // Sorting chain
    bgl_pkg::bgl_state_t      state_reg, state_next;
    bgl_pkg::bgl_cell_ctrl_t  cell_ctrl;
    logic [SW-1:0]            cval [SAMPLES];
    logic                     cvalid [SAMPLES];
    logic                     clt [SAMPLES];

    genvar g;
    generate
        for (g = 0; g < SAMPLES; g++)
        begin : g_cell
            logic [SW-1:0] pv, nv;
            logic          pvalid, plt;
            if (g == 0)
            begin : g_first
                assign pv     = '0;
                assign pvalid = 1'b1;
                assign plt    = 1'b0;
            end
            else
            begin : g_rest
                assign pv     = cval[g-1];
                assign pvalid = cvalid[g-1];
                assign plt    = clt[g-1];
            end
            if (g == SAMPLES - 1)
            begin : g_last
                assign nv = '0;
            end
            else
            begin : g_mid
                assign nv = cval[g+1];
            end
            bgl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .x          (sample),
                .prev_val   (pv),
                .prev_valid (pvalid),
                .prev_lt    (plt),
                .next_val   (nv),
                .val        (cval[g]),
                .valid      (cvalid[g]),
                .lt         (clt[g])
            );
        end
    endgenerate

    // Percent divider
    logic          div_start;
    logic [DW-1:0] div_num, div_den, div_quo;
    logic          div_done;

    bgl_div #(.W(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    // Control and datapath state
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [LW-1:0]    fresh_reg, fresh_next;
    logic [LW-1:0]    ema_reg, ema_next;
    logic             seeded_reg, seeded_next;
    logic [PW-1:0]    rep_reg, rep_next;
    logic             pvalid_reg, pvalid_next;
    logic             chg_reg, chg_next;
    logic [PW-1:0]    p_reg, p_next;
    logic             rej_reg, rej_next;
    logic             ov_reg, ov_next;
    logic [PW-1:0]    opct_reg, opct_next;
    logic             ochg_reg, ochg_next;
    logic [LW-1:0]    olvl_reg, olvl_next;
    logic             orej_reg, orej_next;

    logic               in_xfer;
    logic               out_free;
    logic               in_range;
    logic [LW+1:0]      ema_sum;
    logic [LW-1:0]      span;
    logic [LW-1:0]      lv_off;
    logic [PW-1:0]      pdiff;
    logic [PW-1:0]      q_pct;
    logic [MEAN_N-1:0]  mean_x;
    logic [MEAN_PW-1:0] mean_prod;
    logic [LW-1:0]      mean_q;

    assign in_ready = (state_reg == bgl_pkg::ST_COLLECT);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !ov_reg || out_ready;
    assign in_range = (cnt_reg >= CNT_W'(EFF_TRIM)) && (cnt_reg < CNT_W'(SAMPLES - EFF_TRIM));
    assign ema_sum  = {2'b00, fresh_reg} + {2'b00, ema_reg} + {1'b0, ema_reg, 1'b0};
    assign span     = full_reg - empty_reg;
    assign lv_off   = ema_reg - empty_reg;
    assign pdiff    = (p_reg >= rep_reg) ? (p_reg - rep_reg) : (rep_reg - p_reg);
    assign q_pct    = (div_quo > DW'(bgl_pkg::PCT_FULL)) ? bgl_pkg::PCT_FULL : div_quo[PW-1:0];

    // Trimmed mean in counts with 4 fraction bits
    assign mean_x    = {acc_reg, 4'b0000};
    assign mean_prod = MEAN_PW'(mean_x) * MEAN_PW'(MEAN_M);
    assign mean_q    = mean_prod[MEAN_SH +: LW];

    // Next state and datapath updates
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        fresh_next  = fresh_reg;
        ema_next    = ema_reg;
        seeded_next = seeded_reg;
        rep_next    = rep_reg;
        pvalid_next = pvalid_reg;
        chg_next    = chg_reg;
        p_next      = p_reg;
        rej_next    = rej_reg;
        ov_next     = ov_reg && !out_ready;
        opct_next   = opct_reg;
        ochg_next   = ochg_reg;
        olvl_next   = olvl_reg;
        orej_next   = orej_reg;
        cell_ctrl   = '0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;

        unique case (state_reg)
            bgl_pkg::ST_COLLECT:
            begin
                if (in_xfer)
                begin
                    cell_ctrl.insert = 1'b1;
                    if (cnt_reg == CNT_W'(SAMPLES - 1))
                    begin
                        cnt_next   = '0;
                        acc_next   = '0;
                        state_next = bgl_pkg::ST_SUM;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            bgl_pkg::ST_SUM:
            begin
                // Advance the sorted chain, sum the kept slots
                cell_ctrl.shift = 1'b1;
                if (in_range)
                begin
                    acc_next = acc_reg + SUM_W'(cval[0]);
                end
                if (cnt_reg == CNT_W'(SAMPLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = bgl_pkg::ST_MEAN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bgl_pkg::ST_MEAN:
            begin
                cell_ctrl.clear = 1'b1;
                fresh_next      = mean_q;
                state_next      = bgl_pkg::ST_CHECK;
            end
            bgl_pkg::ST_CHECK:
            begin
                if (fresh_reg < floor_reg)
                begin
                    rej_next   = 1'b1;
                    state_next = bgl_pkg::ST_UPD;
                end
                else
                begin
                    rej_next    = 1'b0;
                    seeded_next = 1'b1;
                    ema_next    = seeded_reg ? ema_sum[LW+1:2] : fresh_reg;
                    state_next  = bgl_pkg::ST_PCT;
                end
            end
            bgl_pkg::ST_PCT:
            begin
                if (ema_reg <= empty_reg)
                begin
                    p_next     = '0;
                    state_next = bgl_pkg::ST_UPD;
                end
                else if (ema_reg >= full_reg)
                begin
                    p_next     = bgl_pkg::PCT_FULL;
                    state_next = bgl_pkg::ST_UPD;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = DW'(lv_off) * DW'(bgl_pkg::PCT_SCALE2) + DW'(span);
                    div_den    = DW'({span, 1'b0});
                    state_next = bgl_pkg::ST_DIV_PCT;
                end
            end
            bgl_pkg::ST_DIV_PCT:
            begin
                if (div_done)
                begin
                    p_next     = q_pct;
                    state_next = bgl_pkg::ST_UPD;
                end
            end
            bgl_pkg::ST_UPD:
            begin
                // Hold here until the output register is free
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    orej_next  = rej_reg;
                    olvl_next  = ema_reg;
                    state_next = bgl_pkg::ST_COLLECT;
                    if (rej_reg)
                    begin
                        opct_next = rep_reg;
                        ochg_next = chg_reg;
                    end
                    else
                    begin
                        pvalid_next = 1'b1;
                        if (!pvalid_reg || p_reg == '0 || p_reg == bgl_pkg::PCT_FULL ||
                            pdiff >= hyst_reg)
                        begin
                            rep_next  = p_reg;
                            opct_next = p_reg;
                        end
                        else
                        begin
                            opct_next = rep_reg;
                        end
                        if (chg_reg)
                        begin
                            chg_next = !(ema_reg < leave_reg);
                        end
                        else
                        begin
                            chg_next = ema_reg > enter_reg;
                        end
                        ochg_next = chg_next;
                    end
                end
            end
            default:
            begin
                state_next = bgl_pkg::ST_COLLECT;
            end
        endcase
    end

    // State register and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bgl_pkg::ST_COLLECT;
            cnt_reg    <= '0;
            ema_reg    <= '0;
            seeded_reg <= 1'b0;
            rep_reg    <= '0;
            pvalid_reg <= 1'b0;
            chg_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ema_reg    <= ema_next;
            seeded_reg <= seeded_next;
            rep_reg    <= rep_next;
            pvalid_reg <= pvalid_next;
            chg_reg    <= chg_next;
            ov_reg     <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        fresh_reg <= fresh_next;
        p_reg     <= p_next;
        rej_reg   <= rej_next;
        opct_reg  <= opct_next;
        ochg_reg  <= ochg_next;
        olvl_reg  <= olvl_next;
        orej_reg  <= orej_next;
    end

    assign out_valid = ov_reg;
    assign percent   = opct_reg;
    assign charging  = ochg_reg;
    assign level     = olvl_reg;
    assign rejected  = orej_reg;

endmodule
